@@ src/luc_pkg.sv @@
// Shared types, constants and the div255 helper of the layer-under compositor.
package luc_pkg;

  localparam int LINE_DEPTH     = 2048;
  localparam int ADDR_W         = $clog2(LINE_DEPTH);
  localparam int NUM_CHAN       = 4;
  localparam int CHAN_W         = 8;
  localparam int CH_SEL_W       = $clog2(NUM_CHAN);
  localparam int PROD_W         = 2 * CHAN_W;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 8;
  localparam int RES_FIFO_DEPTH = 4;
  localparam int RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
  localparam int RES_CNT_W      = $clog2(RES_FIFO_DEPTH + 1);
  localparam int INFLIGHT_W     = 2;

  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [CHAN_W-1:0]   chan_t;
  typedef chan_t [NUM_CHAN-1:0] pixel_t;
  typedef logic [PROD_W-1:0]   prod_t;

  localparam chan_t FULL_ALPHA = {CHAN_W{1'b1}};

  typedef enum logic {
    KIND_COMPOSITE = 1'b0,
    KIND_READOUT   = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA_ENABLE  = 2'd0,
    REG_ALPHA_CHANNEL = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    kind_t  kind;
    addr_t  position;
    pixel_t src;
  } item_t;

  typedef struct packed {
    logic                enable;
    logic [CH_SEL_W-1:0] channel;
  } blend_cfg_t;

  typedef struct packed {
    logic   en;
    addr_t  addr;
    pixel_t data;
  } mem_wr_t;

  typedef struct packed {
    addr_t  position;
    pixel_t px;
  } result_t;

  typedef struct packed {
    logic                  addr_clash;
    logic [INFLIGHT_W-1:0] readouts;
  } pipe_stat_t;

  // Exact floor(x / 255) for any product of two 8-bit values.
  function automatic chan_t div255(input prod_t x);
    logic [PROD_W:0] t;
    t = {1'b0, x} + (PROD_W + 1)'(x >> CHAN_W) + (PROD_W + 1)'(1);
    return t[PROD_W-1:CHAN_W];
  endfunction

endpackage

@@ src/luc_in_if.sv @@
// Input channel interface: composite and readout beats.
interface luc_in_if import luc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [ADDR_W-1:0]     position;
  logic [CHAN_W-1:0]     chan0;
  logic [CHAN_W-1:0]     chan1;
  logic [CHAN_W-1:0]     chan2;
  logic [CHAN_W-1:0]     chan3;

  modport source (output valid, kind, position, chan0, chan1, chan2, chan3, input ready);
  modport sink   (input valid, kind, position, chan0, chan1, chan2, chan3, output ready);
endinterface

@@ src/luc_out_if.sv @@
// Result channel interface: read-out pixel beats.
interface luc_out_if import luc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [ADDR_W-1:0]     out_position;
  logic [CHAN_W-1:0]     out0;
  logic [CHAN_W-1:0]     out1;
  logic [CHAN_W-1:0]     out2;
  logic [CHAN_W-1:0]     out3;

  modport source (output valid, out_position, out0, out1, out2, out3, input ready);
  modport sink   (input valid, out_position, out0, out1, out2, out3, output ready);
endinterface

@@ src/luc_cfg_if.sv @@
// Configuration write channel interface.
interface luc_cfg_if import luc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/luc_line_store.sv @@
// Line store memory with its clearing sweep after reset.
module luc_line_store import luc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    rd_en,
  input  addr_t   rd_addr,
  output pixel_t  rd_data,
  input  mem_wr_t wr,
  output logic    busy
);

  pixel_t mem_r [LINE_DEPTH];
  pixel_t rd_data_r;
  addr_t  clr_idx_r;
  logic   busy_r;
  mem_wr_t wr_mux;

  always_comb begin
    if (busy_r) begin
      wr_mux.en   = 1'b1;
      wr_mux.addr = clr_idx_r;
      wr_mux.data = '0;
    end else begin
      wr_mux = wr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_idx_r <= '0;
    end else if (busy_r) begin
      clr_idx_r <= clr_idx_r + ADDR_W'(1);
      if (clr_idx_r == ADDR_W'(LINE_DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_mux.en) begin
      mem_r[wr_mux.addr] <= wr_mux.data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

  a_no_write_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !wr.en)
    else $error("pipeline write issued during the clearing sweep");

endmodule

@@ src/luc_blend_pipe.sv @@
// Read-modify-write pipeline that blends source pixels under the stored line.
module luc_blend_pipe import luc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  item_t      in_item,
  input  blend_cfg_t cfg,
  output logic       rd_en,
  output addr_t      rd_addr,
  input  pixel_t     rd_data,
  output mem_wr_t    wr,
  output logic       push,
  output result_t    push_res,
  output pipe_stat_t stat
);

  logic   s1_valid_r;
  item_t  s1_item_r;

  logic   s2_valid_r;
  kind_t  s2_kind_r;
  addr_t  s2_pos_r;
  pixel_t s2_old_r;
  pixel_t s2_src_r;
  logic   s2_blend_r;
  prod_t  s2_prod_r [NUM_CHAN];

  logic   wb_valid_r;
  addr_t  wb_addr_r;
  pixel_t wb_data_r;

  pixel_t old_px;
  chan_t  weight;
  prod_t  prod_nxt [NUM_CHAN];
  pixel_t new_px;

  assign rd_en   = in_fire;
  assign rd_addr = in_item.position;

  // The last write-back has not reached the memory read that this item saw.
  assign old_px = (wb_valid_r && (wb_addr_r == s1_item_r.position)) ? wb_data_r : rd_data;
  assign weight = FULL_ALPHA - old_px[cfg.channel];

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      prod_nxt[c] = {{CHAN_W{1'b0}}, s1_item_r.src[c]} * {{CHAN_W{1'b0}}, weight};
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      new_px[c] = s2_blend_r ? (s2_old_r[c] + div255(s2_prod_r[c])) : s2_src_r[c];
    end
  end

  always_comb begin
    wr.en   = s2_valid_r;
    wr.addr = s2_pos_r;
    wr.data = (s2_kind_r == KIND_READOUT) ? '0 : new_px;
  end

  assign push              = s2_valid_r && (s2_kind_r == KIND_READOUT);
  assign push_res.position = s2_pos_r;
  assign push_res.px       = s2_old_r;

  assign stat.addr_clash = s1_valid_r && (s1_item_r.position == in_item.position);
  assign stat.readouts   = INFLIGHT_W'(s1_valid_r && (s1_item_r.kind == KIND_READOUT))
                         + INFLIGHT_W'(push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      wb_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
      s2_valid_r <= s1_valid_r;
      wb_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
    if (s1_valid_r) begin
      s2_kind_r  <= s1_item_r.kind;
      s2_pos_r   <= s1_item_r.position;
      s2_old_r   <= old_px;
      s2_src_r   <= s1_item_r.src;
      s2_blend_r <= cfg.enable;
      for (int c = 0; c < NUM_CHAN; c++) begin
        s2_prod_r[c] <= prod_nxt[c];
      end
    end
    if (s2_valid_r) begin
      wb_addr_r <= wr.addr;
      wb_data_r <= wr.data;
    end
  end

  a_s2_follows_s1: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> $past(s1_valid_r))
    else $error("second stage holds a beat that never passed the first");

  a_cleared_pixel_forwarded: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && wb_valid_r && (wb_addr_r == s1_item_r.position)
     && $past(s2_kind_r == KIND_READOUT)) |-> (old_px == '0))
    else $error("pixel just read out was not seen as cleared");

  a_no_same_pixel_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_valid_r) |-> (s1_item_r.position != s2_pos_r))
    else $error("two beats for one pixel are in the pipeline together");

endmodule

@@ src/luc_result_fifo.sv @@
// Small result queue that drives the output channel.
module luc_result_fifo import luc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  result_t              push_res,
  output logic [RES_CNT_W-1:0] count,
  luc_out_if.source            out_ch
);

  result_t                ent_r [RES_FIFO_DEPTH];
  logic [RES_PTR_W-1:0]   wr_ptr_r;
  logic [RES_PTR_W-1:0]   rd_ptr_r;
  logic [RES_CNT_W-1:0]   cnt_r;
  logic                   pop;

  assign pop                 = out_ch.valid && out_ch.ready;
  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.out_position = ent_r[rd_ptr_r].position;
  assign out_ch.out0         = ent_r[rd_ptr_r].px[0];
  assign out_ch.out1         = ent_r[rd_ptr_r].px[1];
  assign out_ch.out2         = ent_r[rd_ptr_r].px[2];
  assign out_ch.out3         = ent_r[rd_ptr_r].px[3];
  assign count               = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + RES_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + RES_PTR_W'(1);
      end
      cnt_r <= cnt_r + RES_CNT_W'(push) - RES_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_res;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ((cnt_r < RES_CNT_W'(RES_FIFO_DEPTH)) || pop))
    else $error("result queue overflow");

endmodule

@@ src/layer_under_compositor.sv @@
// Top level of the layer-under line compositor.
//
// Use: each input beat is either a composite (kind 0), which mixes the source
// pixel chan0..chan3 under the pixel stored at its position, or a readout
// (kind 1), which returns the stored pixel on the out channel and clears it.
// Composites produce no result beat. The cfg channel is always ready and
// writes alpha_enable (index 0) and alpha_channel (index 1); other indexes are
// ignored. Configuration is expected to change only while no beats are live.
//
// Throughput is one beat per cycle while in_ch.ready is high. The line store
// is a single-port-write, registered-read memory; each beat reads it when
// accepted, is blended in stages s1 and s2 and is written back from s2. A beat
// for the same position as the beat accepted in the previous cycle is held
// back, since the write-back forwarding covers only the older beat. A readout
// result goes from s2 into the result queue, which offers it on out_ch.
//
// After reset the store is swept to zero, one pixel per cycle, and in_ch.ready
// stays low during the sweep. When the receiver stalls, results gather in a
// four-entry queue, and in_ch.ready drops once the queue plus readouts still
// in the pipeline would fill it.
module layer_under_compositor import luc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  luc_in_if.sink    in_ch,
  luc_out_if.source out_ch,
  luc_cfg_if.sink   cfg_ch
);

  logic                   alpha_enable_r;
  logic [CH_SEL_W-1:0]    alpha_channel_r;
  blend_cfg_t             blend_cfg;

  item_t                  in_item;
  logic                   in_fire;
  logic                   store_busy;
  logic                   rd_en;
  addr_t                  rd_addr;
  pixel_t                 rd_data;
  mem_wr_t                wr;
  logic                   push;
  result_t                push_res;
  pipe_stat_t             stat;
  logic [RES_CNT_W-1:0]   res_count;
  logic [RES_CNT_W:0]     res_pending;

  // Configuration registers.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_enable_r  <= 1'b1;
      alpha_channel_r <= CH_SEL_W'(NUM_CHAN - 1);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_ALPHA_ENABLE: begin
          alpha_enable_r <= cfg_ch.data[0];
        end
        REG_ALPHA_CHANNEL: begin
          alpha_channel_r <= cfg_ch.data[CH_SEL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign blend_cfg.enable  = alpha_enable_r;
  assign blend_cfg.channel = alpha_channel_r;

  // Input beat and admission.
  assign in_item.kind     = kind_t'(in_ch.kind);
  assign in_item.position = in_ch.position;
  assign in_item.src      = {in_ch.chan3, in_ch.chan2, in_ch.chan1, in_ch.chan0};

  // Results already queued plus readouts still on their way to the queue.
  assign res_pending = {1'b0, res_count} + (RES_CNT_W + 1)'(stat.readouts);

  assign in_ch.ready = !store_busy && !stat.addr_clash
                    && (res_pending < (RES_CNT_W + 1)'(RES_FIFO_DEPTH));
  assign in_fire     = in_ch.valid && in_ch.ready;

  luc_line_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr),
    .busy    (store_busy)
  );

  luc_blend_pipe u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_item  (in_item),
    .cfg      (blend_cfg),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr       (wr),
    .push     (push),
    .push_res (push_res),
    .stat     (stat)
  );

  luc_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_res (push_res),
    .count    (res_count),
    .out_ch   (out_ch)
  );

endmodule

@@ bench/tb_layer_under_compositor.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the layer-under line compositor.
module tb_layer_under_compositor;
  import luc_pkg::*;

  // Clock period is 10 ns.
  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 12;
  // Quiet cycles allowed before the run is declared hung. The clearing sweep
  // after reset accepts no beat, so the limit sits well above it and above any
  // stall of either side.
  localparam int HANG_LIMIT   = 8192;
  // A composite leaves no result behind. Its write-back comes from pipeline
  // stage s2, and this wait is long enough to cover it.
  localparam int SETTLE       = 8;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 200;
  localparam int HOT_SPOTS    = 8;
  localparam int REPORT_MAX   = 10;

  // Register indexes outside the defined pair; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  // One row of the directed table. Where want_known is set, the expected
  // readout is written out in the row; otherwise the predictor supplies it.
  typedef struct {
    item_t  beat;
    bit     want_known;
    pixel_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  luc_in_if  in_ch();
  luc_out_if out_ch();
  luc_cfg_if cfg_ch();

  layer_under_compositor uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow copy of the line store and the blend settings.
  pixel_t              line_mirror [LINE_DEPTH];
  logic                mirror_alpha_en;
  logic [CH_SEL_W-1:0] mirror_alpha_ch;

  // Readout pixels still to come out of the block, oldest first.
  result_t  pending_pixels[$];
  dir_row_t dir_rows[$];

  int unsigned mismatches;
  int unsigned strays;
  int unsigned leftovers;
  int unsigned composites_done;
  int unsigned readouts_done;
  int unsigned beats_checked;
  int unsigned quiet_cycles;
  bit          send_calm;
  bit          recv_calm;

  always #HALF_PERIOD clk = ~clk;

  // Number of idle cycles before the next beat. Each side now and then
  // switches into a calm stretch where it never idles, and back out again.
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0) begin
      calm = !calm;
    end
    return calm ? 0 : $urandom_range(0, 3);
  endfunction

  // Mix a layer pixel under the stored one. The stored alpha is taken once,
  // before any channel changes; the scaled source is truncated and the sum
  // wraps at eight bits. With blending off the source simply replaces it.
  function automatic pixel_t blend_under(input pixel_t dst, input pixel_t src);
    pixel_t      mixed;
    int unsigned weight;
    int unsigned add;
    if (!mirror_alpha_en) begin
      return src;
    end
    weight = int'(FULL_ALPHA) - int'(dst[mirror_alpha_ch]);
    for (int c = 0; c < NUM_CHAN; c++) begin
      add      = (int'(src[c]) * weight) / int'(FULL_ALPHA);
      mixed[c] = chan_t'(int'(dst[c]) + add);
    end
    return mixed;
  endfunction

  // Update the shadow store for an accepted beat and, for a readout, queue
  // the pixel it must return. A typed-in expectation replaces the predicted
  // one for the rows of the directed table that carry it.
  task automatic track_beat(input item_t beat, input bit want_known, input pixel_t want);
    result_t res;
    if (beat.kind == KIND_COMPOSITE) begin
      line_mirror[beat.position] = blend_under(line_mirror[beat.position], beat.src);
      composites_done++;
    end else begin
      res.position = beat.position;
      res.px       = want_known ? want : line_mirror[beat.position];
      pending_pixels.push_back(res);
      line_mirror[beat.position] = '0;
      readouts_done++;
    end
  endtask

  // Offer one beat on the input channel and hold it until it is taken. The
  // valid line is only lowered when a gap is drawn, so back-to-back beats
  // never see a low and a high assignment in the same step.
  task automatic push_beat(input item_t beat, input bit want_known, input pixel_t want);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= beat.kind;
    in_ch.position <= beat.position;
    in_ch.chan0    <= beat.src[0];
    in_ch.chan1    <= beat.src[1];
    in_ch.chan2    <= beat.src[2];
    in_ch.chan3    <= beat.src[3];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_beat(beat, want_known, want);
  endtask

  // One register write; the shadow settings follow the same masking as the
  // block, keeping only the low bits of the data.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_ALPHA_ENABLE:  mirror_alpha_en = data[0];
      REG_ALPHA_CHANNEL: mirror_alpha_ch = data[CH_SEL_W-1:0];
      default: ;
    endcase
  endtask

  // Wait until every readout has come back, then let the pipeline drain the
  // composites that leave nothing behind.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic table_row(input kind_t kind, input int pos, input pixel_t src,
                           input bit want_known, input pixel_t want);
    dir_row_t row;
    row.beat.kind     = kind;
    row.beat.position = addr_t'(pos);
    row.beat.src      = src;
    row.want_known    = want_known;
    row.want          = want;
    dir_rows.push_back(row);
  endtask

  // One source channel: the extremes often, anything else the rest of the time.
  function automatic chan_t pick_chan();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return FULL_ALPHA;
      default: return chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Initial drive of every block input, and the single reset pulse.
  initial begin
    clk             = 1'b0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.kind      <= KIND_COMPOSITE;
    in_ch.position  <= '0;
    in_ch.chan0     <= '0;
    in_ch.chan1     <= '0;
    in_ch.chan2     <= '0;
    in_ch.chan3     <= '0;
    out_ch.ready    <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_ALPHA_ENABLE;
    cfg_ch.data     <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Stimulus: the directed table first, then random phases, each under its
  // own blend settings.
  initial begin
    item_t  beat;
    addr_t  hot[HOT_SPOTS];
    logic   en_val;
    logic [CH_SEL_W-1:0] ch_val;

    for (int p = 0; p < LINE_DEPTH; p++) begin
      line_mirror[p] = '0;
    end
    mirror_alpha_en = 1'b1;
    mirror_alpha_ch = CH_SEL_W'(NUM_CHAN - 1);

    // Pixel literals read channel 3 down to channel 0; channel 3 holds alpha
    // under the reset settings. Reads straight after reset must see the
    // sweep's zeros, a readout clears its pixel, a composite onto an empty
    // pixel copies the source, and a fully opaque stored pixel takes nothing
    // more. Pairs of beats to the same position test the write-back bypass.
    table_row(KIND_READOUT,   0,     '0,           1'b1, '0);
    table_row(KIND_READOUT,   2047,  '0,           1'b1, '0);
    table_row(KIND_COMPOSITE, 5,     32'hffffffff, 1'b0, '0);
    table_row(KIND_READOUT,   5,     '0,           1'b1, 32'hffffffff);
    table_row(KIND_READOUT,   5,     '0,           1'b1, '0);
    table_row(KIND_COMPOSITE, 2047,  32'h80563412, 1'b0, '0);
    table_row(KIND_COMPOSITE, 2047,  32'hffffffff, 1'b0, '0);
    table_row(KIND_READOUT,   2047,  32'hffffffff, 1'b0, '0);
    table_row(KIND_COMPOSITE, 0,     32'hff000000, 1'b0, '0);
    table_row(KIND_COMPOSITE, 0,     32'hffffffff, 1'b0, '0);
    table_row(KIND_READOUT,   0,     '0,           1'b1, 32'hff000000);
    // Bright colour under a transparent pixel: the channel sums wrap.
    table_row(KIND_COMPOSITE, 1,     32'h00f0f0f0, 1'b0, '0);
    table_row(KIND_COMPOSITE, 1,     32'hffffffff, 1'b0, '0);
    table_row(KIND_READOUT,   1,     '0,           1'b0, '0);
    table_row(KIND_COMPOSITE, 'h555, 32'ha5a5a5a5, 1'b0, '0);
    table_row(KIND_COMPOSITE, 'h2aa, 32'h5a5a5a5a, 1'b0, '0);
    table_row(KIND_COMPOSITE, 'h555, 32'h01ff8000, 1'b0, '0);
    table_row(KIND_READOUT,   'h2aa, 32'hffffffff, 1'b1, 32'h5a5a5a5a);
    table_row(KIND_READOUT,   'h555, '0,           1'b0, '0);
    table_row(KIND_COMPOSITE, 1024,  '0,           1'b0, '0);
    table_row(KIND_READOUT,   1024,  '0,           1'b1, '0);
    table_row(KIND_COMPOSITE, 1023,  32'h7f7f7f7f, 1'b0, '0);
    table_row(KIND_READOUT,   1023,  '0,           1'b1, 32'h7f7f7f7f);

    @(posedge clk);
    while (!rst_n) @(posedge clk);

    foreach (dir_rows[i]) begin
      push_beat(dir_rows[i].beat, dir_rows[i].want_known, dir_rows[i].want);
    end
    drain_block();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // The first phases pin down the extremes: plain overwrite, alpha in
      // channel 0, and the reset settings again. Later phases pick at random.
      case (ph)
        0:       begin en_val = 1'b0; ch_val = CH_SEL_W'(NUM_CHAN - 1); end
        1:       begin en_val = 1'b1; ch_val = '0; end
        2:       begin en_val = 1'b1; ch_val = CH_SEL_W'(NUM_CHAN - 1); end
        default: begin
          en_val = ($urandom_range(0, 3) != 0);
          ch_val = CH_SEL_W'($urandom_range(0, NUM_CHAN - 1));
        end
      endcase
      // Upper data bits are noise that the block must drop, and a write to
      // a spare index must leave the settings alone.
      write_reg(REG_ALPHA_ENABLE,
                {(CFG_DATA_W - 1)'($urandom_range(0, 127)), en_val});
      write_reg(REG_ALPHA_CHANNEL,
                (CFG_DATA_W'($urandom_range(0, 63)) << CH_SEL_W) | CFG_DATA_W'(ch_val));
      write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO,
                CFG_DATA_W'($urandom_range(0, 255)));
      cfg_ch.valid <= 1'b0;

      // A handful of hot positions per phase, so that layers pile up on the
      // same pixels and readouts find something to return. The line ends
      // are always among them.
      hot[0] = '0;
      hot[1] = addr_t'(LINE_DEPTH - 1);
      for (int h = 2; h < HOT_SPOTS; h++) begin
        hot[h] = addr_t'($urandom_range(0, LINE_DEPTH - 1));
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        beat.kind = ($urandom_range(0, 9) < 3) ? KIND_READOUT : KIND_COMPOSITE;
        if ($urandom_range(0, 3) != 0) begin
          beat.position = hot[$urandom_range(0, HOT_SPOTS - 1)];
        end else begin
          beat.position = addr_t'($urandom_range(0, LINE_DEPTH - 1));
        end
        for (int c = 0; c < NUM_CHAN; c++) begin
          beat.src[c] = pick_chan();
        end
        push_beat(beat, 1'b0, '0);
      end
      drain_block();
    end

    leftovers = pending_pixels.size();
    $display("Covered %0d composite and %0d readout beats over %0d blend settings;",
             composites_done, readouts_done, NUM_PHASES + 1);
    $display("%0d readout pixels compared, %0d mismatched, %0d unexpected.",
             beats_checked, mismatches, strays);
    if (mismatches == 0 && strays == 0 && leftovers == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiving side: stall for a random number of cycles before each beat,
  // then compare what arrives with the oldest pixel still owed.
  initial begin
    int      gap;
    result_t got;
    result_t want;
    bit      bad;

    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap(recv_calm);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.position = out_ch.out_position;
      got.px[0]    = out_ch.out0;
      got.px[1]    = out_ch.out1;
      got.px[2]    = out_ch.out2;
      got.px[3]    = out_ch.out3;
      if (pending_pixels.size() == 0) begin
        strays++;
        if (mismatches + strays <= REPORT_MAX) begin
          $display("unexpected readout beat: pos %0d px %h", got.position, got.px);
        end
      end else begin
        want = pending_pixels.pop_front();
        beats_checked++;
        bad = (got.position != want.position);
        for (int c = 0; c < NUM_CHAN; c++) begin
          bad |= (got.px[c] != want.px[c]);
        end
        if (bad) begin
          mismatches++;
          if (mismatches + strays <= REPORT_MAX) begin
            $display("readout mismatch: expected pos %0d px %h, got pos %0d px %h",
                     want.position, want.px, got.position, got.px);
          end
        end
      end
    end
  end

  // Hang detector: counts consecutive cycles in which no channel moves a beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
      $display("no beat moved for %0d cycles, %0d readouts still owed",
               HANG_LIMIT, pending_pixels.size());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
